[rtl/core/tcba_pkg.sv]
`default_nettype none

package tcba_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int BYTE_WIDTH  = 48;
    localparam int TAG_W       = 8;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    // Input staging buffer between the front and the back.
    localparam int FQ_AW    = 1;
    localparam int FQ_DEPTH = 1 << FQ_AW;

    localparam int APB_AW = 4;
    localparam int APB_DW = 64;

    localparam logic [APB_AW-1:0] ADDR_TOTAL   = 4'h0;
    localparam logic [APB_AW-1:0] ADDR_RESERVE = 4'h8;

    localparam logic [1:0] OP_ADMIT   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_RECHECK = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    localparam logic [1:0] KIND_GRANT  = 2'd0;
    localparam logic [1:0] KIND_QUEUED = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    typedef logic [BYTE_WIDTH-1:0] t_bytes;
    typedef logic [TAG_W-1:0]      t_tag;
    typedef logic [QAW-1:0]        t_qidx;
    typedef logic [QCW-1:0]        t_qcnt;

    typedef struct packed {
        logic [1:0] op;
        logic       high;
        t_bytes     bytes;
        t_tag       tag;
    } t_cmd;

    typedef struct packed {
        t_tag   tag;
        t_bytes bytes;
    } t_qent;

    typedef struct packed {
        logic push;
        logic pop;
    } t_qctl;

    function automatic t_bytes sat_add(input t_bytes a, input t_bytes b);
        logic [BYTE_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[BYTE_WIDTH] ? {BYTE_WIDTH{1'b1}} : s[BYTE_WIDTH-1:0];
    endfunction

    function automatic t_qidx next_idx(input t_qidx idx);
        return (idx == QAW'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

endpackage

`default_nettype wire

[rtl/core/tcba_front.sv]
`default_nettype none

module tcba_front import tcba_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [1:0]        i_req_type,
    input  wire logic              i_is_high,
    input  wire logic [BYTE_WIDTH-1:0] i_request_bytes,
    input  wire logic [TAG_W-1:0]  i_request_tag,
    output logic                   o_cmd_valid,
    output t_cmd                   o_cmd,
    input  wire logic              i_pop
);

    t_cmd                r_mem [FQ_DEPTH];
    logic [FQ_AW-1:0]    r_wp;
    logic [FQ_AW-1:0]    r_rp;
    logic [FQ_AW:0]      r_cnt;
    t_cmd                w_cmd;
    logic                w_push;

    // The request type codes are the operation codes, unused type included.
    always_comb begin
        w_cmd.high  = i_is_high;
        w_cmd.bytes = i_request_bytes;
        w_cmd.tag   = i_request_tag;
        w_cmd.op    = i_req_type;
    end

    assign o_ready     = (r_cnt != (FQ_AW+1)'(FQ_DEPTH));
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({w_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/tcba_cq.sv]
`default_nettype none

module tcba_cq import tcba_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_qctl i_ctl,
    input  wire t_qent i_ent,
    output t_qent      o_head,
    output t_qcnt      o_count
);

    t_qent r_mem [QUEUE_DEPTH];
    t_qent r_rd;
    t_qidx r_head;
    t_qidx r_tail;
    t_qcnt r_count;

    // Head entry is read through a register; the back waits for it after a pop.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_tail] <= i_ent;
        end
        r_rd <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_ctl.push) begin
                r_tail <= next_idx(r_tail);
            end
            if (i_ctl.pop) begin
                r_head <= next_idx(r_head);
            end
            case ({i_ctl.push, i_ctl.pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head  = r_rd;
    assign o_count = r_count;

endmodule

`default_nettype wire

[rtl/core/tcba_back.sv]
`default_nettype none

module tcba_back import tcba_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_bytes     i_total,
    input  wire t_bytes     i_reserve,
    input  wire logic       i_cfg_wr,
    input  wire logic       i_cmd_valid,
    input  wire t_cmd       i_cmd,
    output logic            o_cmd_pop,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [1:0]      o_kind,
    output t_tag            o_grant_tag,
    output logic            o_grant_high,
    output t_bytes          o_grant_bytes,
    output logic            o_last
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_DRAIN_H = 3'd2;
    localparam logic [2:0] S_DRAIN_L = 3'd3;
    localparam logic [2:0] S_DONE    = 3'd4;

    // Cycles for the derived budget terms to follow a usage or register change.
    localparam logic [1:0] SETTLE = 2'd2;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [1:0] r_settle;
    t_cmd       r_cmd;
    t_bytes     r_used_high;
    t_bytes     r_used_low;

    t_bytes     r_sum;
    t_bytes     r_lcap;
    t_bytes     r_free;
    t_bytes     r_lfree;
    logic       r_over;
    logic       r_lover;
    logic       r_zero;

    logic       r_ovalid;
    logic [1:0] r_okind;
    t_tag       r_otag;
    logic       r_ohigh;
    t_bytes     r_obytes;
    logic       r_olast;

    t_qctl      w_hq_ctl;
    t_qctl      w_lq_ctl;
    t_qent      w_push_ent;
    t_qent      w_hq_head;
    t_qent      w_lq_head;
    t_qcnt      w_hq_count;
    t_qcnt      w_lq_count;

    logic       w_out_free;
    logic       w_load;
    logic       w_emit;
    logic [1:0] w_kind;
    t_tag       w_tag;
    logic       w_high;
    t_bytes     w_bytes;
    logic       w_last;
    logic       w_mark;
    logic       w_rel;
    logic       w_ok;
    logic       w_full;
    logic       c_high;
    t_bytes     c_bytes;
    t_tag       c_tag;

    tcba_cq u_hq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_hq_ctl),
        .i_ent   (w_push_ent),
        .o_head  (w_hq_head),
        .o_count (w_hq_count)
    );

    tcba_cq u_lq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_lq_ctl),
        .i_ent   (w_push_ent),
        .o_head  (w_lq_head),
        .o_count (w_lq_count)
    );

    // Budget terms, recomputed every cycle from the usage and the registers.
    always_ff @(posedge i_clk) begin
        r_sum   <= sat_add(r_used_high, r_used_low);
        r_lcap  <= i_total - ((i_reserve < i_total) ? i_reserve : i_total);
        r_free  <= i_total - r_sum;
        r_over  <= (r_sum > i_total);
        r_zero  <= (r_sum == '0);
        r_lfree <= r_lcap - r_used_low;
        r_lover <= (r_used_low > r_lcap);
    end

    always_comb begin
        case (r_state)
            S_DRAIN_H: begin
                c_high  = 1'b1;
                c_bytes = w_hq_head.bytes;
                c_tag   = w_hq_head.tag;
            end
            S_DRAIN_L: begin
                c_high  = 1'b0;
                c_bytes = w_lq_head.bytes;
                c_tag   = w_lq_head.tag;
            end
            default: begin
                c_high  = r_cmd.high;
                c_bytes = r_cmd.bytes;
                c_tag   = r_cmd.tag;
            end
        endcase
    end

    always_comb begin
        if (i_total == '0) begin
            w_ok = 1'b1;
        end else if (c_bytes > i_total) begin
            w_ok = r_zero;
        end else if (r_over || (c_bytes > r_free)) begin
            w_ok = 1'b0;
        end else if (c_high) begin
            w_ok = 1'b1;
        end else if (w_hq_count != '0) begin
            w_ok = 1'b0;
        end else if (c_bytes > r_lcap) begin
            w_ok = r_zero;
        end else begin
            w_ok = !r_lover && (c_bytes <= r_lfree);
        end
    end

    assign w_out_free = !r_ovalid || i_ready;
    assign w_full     = c_high ? (w_hq_count == QCW'(QUEUE_DEPTH))
                               : (w_lq_count == QCW'(QUEUE_DEPTH));
    assign w_push_ent = '{tag: r_cmd.tag, bytes: r_cmd.bytes};

    always_comb begin
        n_state  = r_state;
        w_load   = 1'b0;
        w_emit   = 1'b0;
        w_kind   = KIND_GRANT;
        w_tag    = c_tag;
        w_high   = c_high;
        w_bytes  = c_bytes;
        w_last   = 1'b0;
        w_mark   = 1'b0;
        w_rel    = 1'b0;
        w_hq_ctl = '0;
        w_lq_ctl = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && (r_settle == '0)) begin
                    w_load  = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_cmd.op)
                    OP_ADMIT: begin
                        if (w_out_free) begin
                            w_emit  = 1'b1;
                            w_last  = 1'b1;
                            n_state = S_IDLE;
                            if (w_ok) begin
                                w_kind = KIND_GRANT;
                                w_mark = 1'b1;
                            end else if (w_full) begin
                                w_kind = KIND_REJECT;
                            end else begin
                                w_kind        = KIND_QUEUED;
                                w_hq_ctl.push = c_high;
                                w_lq_ctl.push = !c_high;
                            end
                        end
                    end
                    OP_RELEASE: begin
                        w_rel   = 1'b1;
                        n_state = S_DRAIN_H;
                    end
                    OP_RECHECK: begin
                        n_state = S_DRAIN_H;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DRAIN_H: begin
                if (r_settle == '0) begin
                    if ((w_hq_count != '0) && w_ok) begin
                        if (w_out_free) begin
                            w_emit       = 1'b1;
                            w_mark       = 1'b1;
                            w_hq_ctl.pop = 1'b1;
                        end
                    end else begin
                        n_state = S_DRAIN_L;
                    end
                end
            end
            S_DRAIN_L: begin
                if (r_settle == '0) begin
                    if ((w_lq_count != '0) && w_ok) begin
                        if (w_out_free) begin
                            w_emit       = 1'b1;
                            w_mark       = 1'b1;
                            w_lq_ctl.pop = 1'b1;
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    w_kind  = KIND_DONE;
                    w_tag   = '0;
                    w_high  = 1'b0;
                    w_bytes = '0;
                    w_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd_pop = w_load;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cmd <= i_cmd;
        end
        if (w_emit) begin
            r_okind  <= w_kind;
            r_otag   <= w_tag;
            r_ohigh  <= w_high;
            r_obytes <= w_bytes;
            r_olast  <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_settle    <= SETTLE;
            r_used_high <= '0;
            r_used_low  <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_mark || w_rel || i_cfg_wr) begin
                r_settle <= SETTLE;
            end else if (r_settle != '0) begin
                r_settle <= r_settle - 1'b1;
            end
            if (w_mark) begin
                if (c_high) begin
                    r_used_high <= sat_add(r_used_high, c_bytes);
                end else begin
                    r_used_low <= sat_add(r_used_low, c_bytes);
                end
            end
            if (w_rel) begin
                // A release larger than the usage empties that class.
                if (r_cmd.high) begin
                    r_used_high <= (r_cmd.bytes > r_used_high) ? '0
                                                               : r_used_high - r_cmd.bytes;
                end else begin
                    r_used_low <= (r_cmd.bytes > r_used_low) ? '0
                                                             : r_used_low - r_cmd.bytes;
                end
            end
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_ovalid;
    assign o_kind        = r_okind;
    assign o_grant_tag   = r_otag;
    assign o_grant_high  = r_ohigh;
    assign o_grant_bytes = r_obytes;
    assign o_last        = r_olast;

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_hq_ctl.pop || w_lq_ctl.pop) |->
        ((w_hq_ctl.pop && (w_hq_count != '0)) || (w_lq_ctl.pop && (w_lq_count != '0))))
        else $error("queue popped while empty");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_hq_ctl.push || w_lq_ctl.push) |->
        ((w_hq_ctl.push && (w_hq_count < QCW'(QUEUE_DEPTH))) ||
         (w_lq_ctl.push && (w_lq_count < QCW'(QUEUE_DEPTH)))))
        else $error("queue pushed while full");

    a_drain_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && ((r_state == S_DRAIN_H) || (r_state == S_DRAIN_L))) |->
        ((r_settle == '0) && (w_kind == KIND_GRANT) && !w_last))
        else $error("drain grant issued on stale budget terms");

    a_release_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EXEC) && (r_cmd.op == OP_RELEASE)) |=>
        ((r_state == S_DRAIN_H) && (r_settle == SETTLE)))
        else $error("release did not start a drain");

endmodule

`default_nettype wire

[rtl/core/two_class_budget_admission_unit.sv]
`default_nettype none
// Admit: each request gives a single registered result. After a grant the back waits
// for the budget terms to follow the new usage before it takes the next request;
// queued and rejected admits do not wait for them.
// Release and recheck: the drained grants come first, then the done item.
// Reset (synchronous, active low) empties the wait queues and clears usage and budget
// registers; the back lets the budget terms settle before it takes the first request.

module two_class_budget_admission_unit import tcba_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_AW-1:0]     paddr,
    input  wire logic [APB_DW-1:0]     pwdata,
    output logic      [APB_DW-1:0]     prdata,
    output logic                       pready,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [1:0]            i_req_type,
    input  wire logic                  i_is_high,
    input  wire logic [BYTE_WIDTH-1:0] i_request_bytes,
    input  wire logic [TAG_W-1:0]      i_request_tag,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [1:0]                 o_kind,
    output logic [TAG_W-1:0]           o_grant_tag,
    output logic                       o_grant_high,
    output logic [BYTE_WIDTH-1:0]      o_grant_bytes,
    output logic                       o_last
);

    t_bytes r_total;
    t_bytes r_reserve;
    logic   w_wr;
    logic   w_cmd_valid;
    t_cmd   w_cmd;
    logic   w_cmd_pop;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_reserve <= '0;
        end else if (w_wr) begin
            if (paddr == ADDR_TOTAL) begin
                r_total <= pwdata[BYTE_WIDTH-1:0];
            end
            if (paddr == ADDR_RESERVE) begin
                r_reserve <= pwdata[BYTE_WIDTH-1:0];
            end
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_TOTAL:   prdata = APB_DW'(r_total);
            ADDR_RESERVE: prdata = APB_DW'(r_reserve);
            default:      prdata = '0;
        endcase
    end

    tcba_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_req_type      (i_req_type),
        .i_is_high       (i_is_high),
        .i_request_bytes (i_request_bytes),
        .i_request_tag   (i_request_tag),
        .o_cmd_valid     (w_cmd_valid),
        .o_cmd           (w_cmd),
        .i_pop           (w_cmd_pop)
    );

    tcba_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_total       (r_total),
        .i_reserve     (r_reserve),
        .i_cfg_wr      (w_wr),
        .i_cmd_valid   (w_cmd_valid),
        .i_cmd         (w_cmd),
        .o_cmd_pop     (w_cmd_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_grant_tag   (o_grant_tag),
        .o_grant_high  (o_grant_high),
        .o_grant_bytes (o_grant_bytes),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

[tb/sv/admission_checker.sv]
`timescale 1ns / 1ps

// Watches the register port and the request and result channels, keeps its own copy of the
// budget state and wait queues, and compares every result against the oldest
// predicted one.
module admission_checker import tcba_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    input  logic [1:0]        i_req_type,
    input  logic              i_req_high,
    input  t_bytes            i_req_bytes,
    input  t_tag              i_req_tag,
    input  logic              i_res_valid,
    input  logic              i_res_ready,
    input  logic [1:0]        i_res_kind,
    input  t_tag              i_res_tag,
    input  logic              i_res_high,
    input  t_bytes            i_res_bytes,
    input  logic              i_res_last,
    output int                o_outstanding,
    output int                o_fail_count
);

    typedef struct packed {
        logic [1:0] kind;
        t_tag       tag;
        logic       high;
        t_bytes     bytes;
        logic       last;
    } t_outcome;

    t_outcome outcomes_due[$];
    t_qent    high_wait[$];
    t_qent    low_wait[$];

    t_bytes budget_total;
    t_bytes budget_reserve;
    t_bytes used_high;
    t_bytes used_low;
    int     fail_total = 0;

    t_outcome want;
    t_outcome seen;

    function automatic t_bytes add_clamped(input t_bytes a, input t_bytes b);
        logic [BYTE_WIDTH:0] total;
        total = {1'b0, a} + {1'b0, b};
        return total[BYTE_WIDTH] ? '1 : total[BYTE_WIDTH-1:0];
    endfunction

    function automatic void queue_outcome(input logic [1:0] kind, input t_tag tag,
                                          input logic high, input t_bytes bytes,
                                          input logic last);
        t_outcome item;
        item.kind  = kind;
        item.tag   = tag;
        item.high  = high;
        item.bytes = bytes;
        item.last  = last;
        outcomes_due = {outcomes_due, item};
    endfunction

    function automatic bit fits_budget(input bit high, input t_bytes bytes);
        t_bytes in_use;
        t_bytes reserve;
        t_bytes low_cap;
        if (budget_total == '0) return 1'b1;
        in_use = add_clamped(used_high, used_low);
        // An oversized request only goes through on an empty budget.
        if (bytes > budget_total) return in_use == '0;
        if (in_use > budget_total || bytes > budget_total - in_use) return 1'b0;
        if (high) return 1'b1;
        if (high_wait.size() != 0) return 1'b0;
        reserve = (budget_reserve < budget_total) ? budget_reserve : budget_total;
        low_cap = budget_total - reserve;
        if (bytes > low_cap) return in_use == '0;
        return used_low <= low_cap && bytes <= low_cap - used_low;
    endfunction

    function automatic void drain_waiting();
        t_qent ent;
        while (high_wait.size() != 0 && fits_budget(1'b1, high_wait[0].bytes)) begin
            ent = high_wait[0];
            high_wait.delete(0);
            used_high = add_clamped(used_high, ent.bytes);
            queue_outcome(KIND_GRANT, ent.tag, 1'b1, ent.bytes, 1'b0);
        end
        while (low_wait.size() != 0 && fits_budget(1'b0, low_wait[0].bytes)) begin
            ent = low_wait[0];
            low_wait.delete(0);
            used_low = add_clamped(used_low, ent.bytes);
            queue_outcome(KIND_GRANT, ent.tag, 1'b0, ent.bytes, 1'b0);
        end
    endfunction

    function automatic void predict_request(input logic [1:0] op, input logic high,
                                            input t_bytes bytes, input t_tag tag);
        t_qent ent;
        ent.tag   = tag;
        ent.bytes = bytes;
        case (op)
            OP_ADMIT: begin
                if (fits_budget(high, bytes)) begin
                    if (high) used_high = add_clamped(used_high, bytes);
                    else used_low = add_clamped(used_low, bytes);
                    queue_outcome(KIND_GRANT, tag, high, bytes, 1'b1);
                end else if ((high ? high_wait.size() : low_wait.size()) >= QUEUE_DEPTH) begin
                    queue_outcome(KIND_REJECT, tag, high, bytes, 1'b1);
                end else begin
                    if (high) high_wait = {high_wait, ent};
                    else low_wait = {low_wait, ent};
                    queue_outcome(KIND_QUEUED, tag, high, bytes, 1'b1);
                end
            end
            OP_RELEASE: begin
                if (high) used_high = (bytes > used_high) ? '0 : used_high - bytes;
                else used_low = (bytes > used_low) ? '0 : used_low - bytes;
                drain_waiting();
                queue_outcome(KIND_DONE, '0, 1'b0, '0, 1'b1);
            end
            OP_RECHECK: begin
                drain_waiting();
                queue_outcome(KIND_DONE, '0, 1'b0, '0, 1'b1);
            end
            default: begin
                queue_outcome(KIND_DONE, '0, 1'b0, '0, 1'b1);
            end
        endcase
    endfunction

    function automatic void check_field(input string field, input logic [63:0] expected_val,
                                        input logic [63:0] actual_val);
        if (expected_val !== actual_val) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, expected_val, actual_val);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            outcomes_due.delete();
            high_wait.delete();
            low_wait.delete();
            budget_total   = '0;
            budget_reserve = '0;
            used_high      = '0;
            used_low       = '0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == ADDR_TOTAL) budget_total = i_pwdata[BYTE_WIDTH-1:0];
                else if (i_paddr == ADDR_RESERVE) budget_reserve = i_pwdata[BYTE_WIDTH-1:0];
            end
            if (i_req_valid && i_req_ready) begin
                predict_request(i_req_type, i_req_high, i_req_bytes, i_req_tag);
            end
            if (i_res_valid && i_res_ready) begin
                seen = '{i_res_kind, i_res_tag, i_res_high, i_res_bytes, i_res_last};
                if (outcomes_due.size() == 0) begin
                    $error("unexpected result: kind %0d tag 0x%0h bytes 0x%0h",
                           seen.kind, seen.tag, seen.bytes);
                    fail_total++;
                end else begin
                    want = outcomes_due[0];
                    outcomes_due.delete(0);
                    check_field("kind", want.kind, seen.kind);
                    check_field("grant_tag", want.tag, seen.tag);
                    check_field("grant_high", want.high, seen.high);
                    check_field("grant_bytes", want.bytes, seen.bytes);
                    check_field("last", want.last, seen.last);
                end
            end
        end
        o_outstanding <= outcomes_due.size();
        o_fail_count  <= fail_total;
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import tcba_pkg::*;

    localparam t_bytes BYTES_MAX = '1;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    logic       i_valid         = 1'b0;
    logic       o_ready;
    logic [1:0] i_req_type      = OP_ADMIT;
    logic       i_is_high       = 1'b0;
    t_bytes     i_request_bytes = '0;
    t_tag       i_request_tag   = '0;

    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [1:0] o_kind;
    t_tag       o_grant_tag;
    logic       o_grant_high;
    t_bytes     o_grant_bytes;
    logic       o_last;

    int outstanding;
    int fail_count;
    bit calm = 1'b0;

    two_class_budget_admission_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_req_type      (i_req_type),
        .i_is_high       (i_is_high),
        .i_request_bytes (i_request_bytes),
        .i_request_tag   (i_request_tag),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_grant_tag     (o_grant_tag),
        .o_grant_high    (o_grant_high),
        .o_grant_bytes   (o_grant_bytes),
        .o_last          (o_last)
    );

    admission_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_req_valid   (i_valid),
        .i_req_ready   (o_ready),
        .i_req_type    (i_req_type),
        .i_req_high    (i_is_high),
        .i_req_bytes   (i_request_bytes),
        .i_req_tag     (i_request_tag),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_res_kind    (o_kind),
        .i_res_tag     (o_grant_tag),
        .i_res_high    (o_grant_high),
        .i_res_bytes   (o_grant_bytes),
        .i_res_last    (o_last),
        .o_outstanding (outstanding),
        .o_fail_count  (fail_count)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #12_000_000;
        $display("two_class_budget_admission_unit regression: fail");
        $finish;
    end

    // Result side: random stall bursts, none once the run has gone calm.
    initial begin
        @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    end

    function automatic t_bytes bytes_upto(input t_bytes lim);
        logic [63:0] wide;
        if (lim <= t_bytes'(32'hFFFF_FFFF)) return t_bytes'($urandom_range(0, 32'(lim)));
        wide = {$urandom, $urandom};
        return t_bytes'(wide % ({16'h0, lim} + 64'd1));
    endfunction

    function automatic t_bytes pick_bytes(input t_bytes scale);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4) return t_bytes'({$urandom, $urandom});
        if (roll < 8) return '0;
        if (roll < 12) return scale + t_bytes'($urandom_range(0, 1));
        if (roll < 70) return bytes_upto(scale / 8 + 1);
        return bytes_upto(scale);
    endfunction

    function automatic t_cmd random_cmd(input t_bytes scale, input int admit_pct);
        t_cmd cmd;
        int   roll;
        roll = $urandom_range(0, 99);
        if (roll < admit_pct) cmd.op = OP_ADMIT;
        else if (roll < admit_pct + (100 - admit_pct) * 7 / 10) cmd.op = OP_RELEASE;
        else if (roll < 97) cmd.op = OP_RECHECK;
        else cmd.op = OP_NONE;
        cmd.high  = 1'($urandom_range(0, 1));
        cmd.bytes = pick_bytes(scale);
        cmd.tag   = t_tag'($urandom_range(0, 255));
        return cmd;
    endfunction

    task automatic send_cmd(input t_cmd cmd);
        i_valid         <= 1'b1;
        i_req_type      <= cmd.op;
        i_is_high       <= cmd.high;
        i_request_bytes <= cmd.bytes;
        i_request_tag   <= cmd.tag;
        do @(posedge i_clk); while (!o_ready);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    // The outstanding count is registered, so it is read only after an edge has passed.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [APB_AW-1:0] addr, input t_bytes value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_budget(input t_bytes total, input t_bytes reserve);
        wait_drained();
        repeat (8) @(posedge i_clk);
        // The reserve is clamped on use, so the write order must not matter.
        if ($urandom_range(0, 1)) begin
            write_reg(ADDR_TOTAL, total);
            write_reg(ADDR_RESERVE, reserve);
        end else begin
            write_reg(ADDR_RESERVE, reserve);
            write_reg(ADDR_TOTAL, total);
        end
    endtask

    task automatic run_phase(input t_bytes total, input t_bytes reserve, input t_bytes scale,
                             input int admit_pct, input int count, input bit last_phase);
        int hold_at;
        set_budget(total, reserve);
        calm    = last_phase;
        hold_at = $urandom_range(count / 4, 3 * count / 4);
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) wait_drained();
            send_cmd(random_cmd(scale, admit_pct));
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Unlimited budget: usage saturates, releases clear it, odd request types.
        send_cmd('{OP_ADMIT, 1'b1, BYTES_MAX, 8'hFF});
        send_cmd('{OP_ADMIT, 1'b1, BYTES_MAX, 8'h00});
        send_cmd('{OP_ADMIT, 1'b0, '0, 8'h5A});
        send_cmd('{OP_RELEASE, 1'b1, '0, 8'h00});
        send_cmd('{OP_RECHECK, 1'b0, '0, 8'h00});
        send_cmd('{OP_NONE, 1'b1, BYTES_MAX, 8'hA5});
        send_cmd('{OP_RELEASE, 1'b1, BYTES_MAX, 8'h00});
        send_cmd('{OP_RELEASE, 1'b0, t_bytes'(5), 8'h00});

        // Reserve above the total leaves nothing for low priority.
        set_budget(t_bytes'(100), t_bytes'(500));
        send_cmd('{OP_ADMIT, 1'b0, '0, 8'h01});
        send_cmd('{OP_ADMIT, 1'b0, t_bytes'(1), 8'h02});
        send_cmd('{OP_ADMIT, 1'b1, t_bytes'(99), 8'h03});
        send_cmd('{OP_ADMIT, 1'b1, t_bytes'(1), 8'h04});
        send_cmd('{OP_ADMIT, 1'b0, t_bytes'(1), 8'h05});
        send_cmd('{OP_ADMIT, 1'b1, t_bytes'(200), 8'h06});
        send_cmd('{OP_RELEASE, 1'b1, t_bytes'(99), 8'h00});
        send_cmd('{OP_RELEASE, 1'b0, t_bytes'(1), 8'h00});
        send_cmd('{OP_RELEASE, 1'b1, t_bytes'(1), 8'h00});
        send_cmd('{OP_RELEASE, 1'b1, BYTES_MAX, 8'h00});
        send_cmd('{OP_RECHECK, 1'b1, '0, 8'h00});

        run_phase(t_bytes'(1000), t_bytes'(300), t_bytes'(1000), 60, 90, 1'b0);
        run_phase(t_bytes'(64), t_bytes'(64), t_bytes'(64), 70, 60, 1'b0);
        run_phase('0, '0, t_bytes'(1000), 55, 60, 1'b0);
        run_phase(BYTES_MAX, t_bytes'(48'h8000_0000_0000), BYTES_MAX, 60, 60, 1'b0);
        run_phase(t_bytes'(300), BYTES_MAX, t_bytes'(300), 75, 70, 1'b0);
        run_phase(t_bytes'(5000), '0, t_bytes'(5000), 50, 60, 1'b0);
        run_phase(t_bytes'(2000), t_bytes'(700), t_bytes'(2000), 60, 80, 1'b1);

        wait_drained();
        repeat (30) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("two_class_budget_admission_unit regression: pass");
        end else begin
            $display("two_class_budget_admission_unit regression: fail");
        end
        $finish;
    end

endmodule
